/* rtl/core/mpwm_pkg.sv */
// mpwm_pkg: shared types and constants of the magic pattern window matcher
// no dependencies; imported by the core and its checker
package mpwm_pkg;

	// window depth in bytes and width of the offset registers
	localparam int PATTERN_MAX = 16;
	localparam int OFFSET_BITS = 16;

	// longest byte pattern the register file can describe
	localparam int PAT_CAP  = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
	localparam int PAT_SPAN = (PATTERN_MAX > 16) ? PATTERN_MAX : 16;

	// derived widths
	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int IDX_W = $clog2(PATTERN_MAX);
	localparam int POS_W = OFFSET_BITS + 1;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODE           = 3'd0,
		REG_START_OFFSET   = 3'd1,
		REG_END_OFFSET     = 3'd2,
		REG_PATTERN_LENGTH = 3'd3,
		REG_PATTERN_LOW    = 3'd4,
		REG_PATTERN_HIGH   = 3'd5,
		REG_NUMBER_VALUE   = 3'd6
	} reg_index_t;

	// rule modes; the codes above MODE_OFF never match either
	typedef enum logic [2:0] {
		MODE_BYTES    = 3'd0,
		MODE_BIG16    = 3'd1,
		MODE_LITTLE16 = 3'd2,
		MODE_BIG32    = 3'd3,
		MODE_LITTLE32 = 3'd4,
		MODE_OFF      = 3'd5
	} mode_t;

endpackage

/* rtl/core/mpwm_in_if.sv */
// mpwm_in_if: data byte channel of the matcher (valid/ready plus payload)
// depends on nothing but the standard handshake convention
interface mpwm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

/* rtl/core/mpwm_out_if.sv */
// mpwm_out_if: result channel of the matcher (valid/ready plus match flag)
// depends on nothing but the standard handshake convention
interface mpwm_out_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink (input valid, input matched, output ready);
endinterface

/* rtl/core/magic_pattern_window_match_core.sv */
// magic_pattern_window_match_core: streaming magic rule matcher, top level
// depends on mpwm_pkg, mpwm_in_if and mpwm_out_if
//
//  channel  | dir | beat                 | fields
//  ---------+-----+----------------------+---------------------------------
//  in_ch    | in  | one data byte        | data_byte[7:0], last
//  out_ch   | out | one result per data  | matched
//  cfg      | in  | one register write   | cfg_write_en, cfg_index, cfg_data
//
// one byte per cycle sustained; a byte is compared in the cycle after it is taken
// and its result, on the last byte, moves from the compare stage into the result register
// arst_n clears the rule registers to their defaults and empties the pipeline
// a result left untaken holds in_ch.ready low only once a second last byte
// reaches the compare stage; all other bytes keep flowing
module magic_pattern_window_match_core
	import mpwm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	mpwm_in_if.sink                in_ch,
	mpwm_out_if.source             out_ch
);

	// rule registers
	logic [2:0]             mode_q;
	logic [OFFSET_BITS-1:0] start_offset_q;
	logic [OFFSET_BITS-1:0] end_offset_q;
	logic [4:0]             pattern_length_q;
	logic [63:0]            pattern_low_q;
	logic [63:0]            pattern_high_q;
	logic [31:0]            number_value_q;

	// stream state
	logic [7:0]       win_q [PATTERN_MAX];
	logic [POS_W-1:0] pos_q;
	logic             found_q;

	// compare stage
	logic             valid_s1;
	logic             last_s1;
	logic [POS_W-1:0] pos_s1;

	// result register
	logic out_valid_q;
	logic out_matched_q;

	logic in_acc;
	logic s1_go;

	// pattern decode and window compare
	logic [8*PAT_SPAN-1:0] pat_all;
	logic [7:0]            seq [PATTERN_MAX];
	logic [LEN_W-1:0]      n_len;
	logic [PATTERN_MAX-1:0] hit;
	logic [LEN_W-1:0]      k_idx [PATTERN_MAX];
	logic [POS_W:0]        pos_end;
	logic [POS_W:0]        s_off;
	logic                  in_range;
	logic                  match;

	// handshake: the compare stage stalls only on a last byte while the result
	// register is full and not being taken
	assign s1_go        = valid_s1 && !(last_s1 && out_valid_q && !out_ch.ready);
	assign in_ch.ready  = !valid_s1 || s1_go;
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.matched = out_matched_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_OFF;
			start_offset_q   <= '0;
			end_offset_q     <= '0;
			pattern_length_q <= 5'd1;
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			number_value_q   <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_MODE:           mode_q           <= cfg_data[2:0];
				REG_START_OFFSET:   start_offset_q   <= cfg_data[OFFSET_BITS-1:0];
				REG_END_OFFSET:     end_offset_q     <= cfg_data[OFFSET_BITS-1:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[4:0];
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				REG_NUMBER_VALUE:   number_value_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// byte window shift; stale bytes from a previous data never reach the
	// compare because a start before offset zero is rejected by position
	always_ff @(posedge clk) begin
		if (in_acc) begin
			win_q[0] <= in_ch.data_byte;
			for (int j = 1; j < PATTERN_MAX; j++) begin
				win_q[j] <= win_q[j-1];
			end
		end
	end

	// position counter, saturating, back to zero after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc) begin
			if (in_ch.last) begin
				pos_q <= '0;
			end else if (pos_q != {POS_W{1'b1}}) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// compare stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_s1 <= in_ch.last;
			pos_s1  <= pos_q;
		end
	end

	// wanted byte sequence, first byte at index zero
	always_comb begin
		pat_all = (8*PAT_SPAN)'({pattern_high_q, pattern_low_q});
		for (int i = 0; i < PATTERN_MAX; i++) begin
			seq[i] = pat_all[8*i +: 8];
		end
		n_len = '0;
		case (mode_q)
			MODE_BYTES: begin
				if (int'(pattern_length_q) > PAT_CAP) begin
					n_len = LEN_W'(PAT_CAP);
				end else begin
					n_len = LEN_W'(pattern_length_q);
				end
			end
			MODE_BIG16: begin
				n_len  = LEN_W'(2);
				seq[0] = number_value_q[15:8];
				seq[1] = number_value_q[7:0];
			end
			MODE_LITTLE16: begin
				n_len  = LEN_W'(2);
				seq[0] = number_value_q[7:0];
				seq[1] = number_value_q[15:8];
			end
			MODE_BIG32: begin
				n_len  = LEN_W'(4);
				seq[0] = number_value_q[31:24];
				seq[1] = number_value_q[23:16];
				seq[2] = number_value_q[15:8];
				seq[3] = number_value_q[7:0];
			end
			MODE_LITTLE32: begin
				n_len  = LEN_W'(4);
				seq[0] = number_value_q[7:0];
				seq[1] = number_value_q[15:8];
				seq[2] = number_value_q[23:16];
				seq[3] = number_value_q[31:24];
			end
			default: n_len = '0;
		endcase
	end

	// window entry j holds sequence byte n-1-j; entries past the pattern always pass
	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++) begin
			k_idx[j] = n_len - LEN_W'(j) - LEN_W'(1);
			if (LEN_W'(j) >= n_len) begin
				hit[j] = 1'b1;
			end else begin
				hit[j] = (win_q[j] == seq[k_idx[j][IDX_W-1:0]]);
			end
		end
	end

	// start offset of the candidate and its range check
	always_comb begin
		pos_end  = (POS_W+1)'(pos_s1) + (POS_W+1)'(1);
		s_off    = pos_end - (POS_W+1)'(n_len);
		in_range = (s_off >= (POS_W+1)'(start_offset_q))
			&& (s_off <= (POS_W+1)'(end_offset_q));
		match    = (n_len != '0) && (pos_end >= (POS_W+1)'(n_len)) && in_range && (&hit);
	end

	// found flag, cleared once the last byte's result moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (s1_go) begin
			found_q <= last_s1 ? 1'b0 : (found_q || match);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			out_matched_q <= found_q || match;
		end
	end

endmodule

/* rtl/core/mpwm_checker.sv */
// mpwm_checker: port-level assertions on the matcher, bound to the top level
// depends on mpwm_pkg for nothing but keeps the house import form
module mpwm_checker
	import mpwm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_matched
);

	logic       in_beat;
	logic       out_beat;
	logic [1:0] pending_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// last beats taken whose result has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_beat && in_last) - 2'(out_beat);
		end
	end

	// a waiting result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_matched))
		else $error("result dropped or changed while stalled");

	// input back-pressure only comes from a full result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty result register");

	// every result belongs to a last beat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pending_q != 2'd0)
		else $error("result without a last beat");

	// no more than two data ends in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("too many data ends in flight");

endmodule

bind magic_pattern_window_match_core mpwm_checker u_mpwm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_last     (in_ch.last),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_matched (out_ch.matched)
);
